/* src/fcmt_pkg.sv */
// Shared widths, register map codes and helpers for the four channel match timer.
package fcmt_pkg;

    localparam int NUM_CHANNELS = 4;
    localparam int COUNT_WIDTH  = 32;

    localparam int WORD_W  = 32;
    localparam int ADDR_W  = 9;
    localparam int FUNC_W  = 2;
    localparam int ALIAS_W = 4;
    localparam int SEL_W   = ADDR_W - ALIAS_W;
    localparam int SLOT_W  = 2;
    localparam int DIR_W   = 4 * NUM_CHANNELS;
    localparam int ACT_W   = 3 * NUM_CHANNELS;
    localparam int HOLD_LSB = 4;

    // stream word layouts
    localparam int S_TDATA_W = ((ADDR_W + WORD_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((WORD_W + 1 + 7) / 8) * 8;

    typedef logic [FUNC_W-1:0]  func_t;
    typedef logic [ALIAS_W-1:0] alias_t;
    typedef logic [SEL_W-1:0]   reg_sel_t;

    localparam func_t FUNC_TICK  = 2'd0;
    localparam func_t FUNC_READ  = 2'd1;
    localparam func_t FUNC_WRITE = 2'd2;

    localparam alias_t ALIAS_WR  = 4'h0;
    localparam alias_t ALIAS_SET = 4'h4;
    localparam alias_t ALIAS_CLR = 4'h8;

    localparam reg_sel_t REG_IR   = 5'h00;
    localparam reg_sel_t REG_TCR  = 5'h01;
    localparam reg_sel_t REG_DIR  = 5'h02;
    localparam reg_sel_t REG_CNT0 = 5'h03;
    localparam reg_sel_t REG_CNT3 = 5'h06;
    localparam reg_sel_t REG_PR   = 5'h07;
    localparam reg_sel_t REG_PC   = 5'h08;
    localparam reg_sel_t REG_MCR  = 5'h09;
    localparam reg_sel_t REG_MAT0 = 5'h0A;
    localparam reg_sel_t REG_MAT3 = 5'h0D;

    localparam logic [1:0] DIR_DOWN = 2'b01;

    // plain write, set-bits alias or clear-bits alias
    function automatic logic [WORD_W-1:0] merge(input logic [WORD_W-1:0] old_val,
                                                input logic [WORD_W-1:0] w,
                                                input alias_t alias_code);
        logic [WORD_W-1:0] res;
        case (alias_code)
            ALIAS_SET: res = old_val | w;
            ALIAS_CLR: res = old_val & ~w;
            default:   res = w;
        endcase
        return res;
    endfunction

endpackage

/* src/four_channel_match_timer_unit.sv */
// Four channel match timer: prescaler, counters, match control and register access.
//
//  channel | dir | ports                           | word contents (low bit up)
//  --------+-----+---------------------------------+-----------------------------------
//  s_      | in  | s_tvalid s_tready s_tdata s_tuser | tdata: addr[8:0] wdata[40:9];
//          |     |                                 | tuser: func[1:0]
//  m_      | out | m_tvalid m_tready m_tdata       | tdata: rdata[31:0] irq[32]
//
// Flow: one word accepted every cycle while m_tready is high; a result word is
// valid once it moves from the input register into the result register. All
// timer state updates in combinational logic between the two registers.
// Reset: aresetn low, synchronous; clears all timer state and both valid flags.
// Stalls: when m_tready is low the result register holds and the input
// register keeps one more word, then s_tready drops.
module four_channel_match_timer_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [fcmt_pkg::S_TDATA_W-1:0]   s_tdata,   // addr[8:0], wdata[40:9]
    input  logic [fcmt_pkg::FUNC_W-1:0]      s_tuser,   // func[1:0]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [fcmt_pkg::M_TDATA_W-1:0]   m_tdata    // rdata[31:0], irq[32]
);
    import fcmt_pkg::*;

    // input register
    logic                in_valid_reg;
    func_t               func_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [WORD_W-1:0]   wdata_reg;

    // result register
    logic                out_valid_reg;
    logic [WORD_W-1:0]   rdata_reg, rdata_next;
    logic                irq_reg, irq_next;

    // timer state
    logic [NUM_CHANNELS-1:0] flags_reg, flags_next;
    logic [NUM_CHANNELS-1:0] run_reg, run_next;
    logic [NUM_CHANNELS-1:0] hold_reg, hold_next;
    logic [DIR_W-1:0]        dir_reg, dir_next;
    logic [WORD_W-1:0]       pl_reg, pl_next;
    logic [WORD_W-1:0]       pc_reg, pc_next;
    logic [ACT_W-1:0]        act_reg, act_next;
    logic [COUNT_WIDTH-1:0]  mat_reg [NUM_CHANNELS];
    logic [COUNT_WIDTH-1:0]  mat_next [NUM_CHANNELS];
    logic [COUNT_WIDTH-1:0]  cnt_reg [NUM_CHANNELS];
    logic [COUNT_WIDTH-1:0]  cnt_next [NUM_CHANNELS];

    logic advance;

    // the item in the input register moves on whenever the result slot frees up
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({irq_reg, rdata_reg});

    always_comb begin
        alias_t                  alias_v;
        reg_sel_t                sel;
        logic                    alias_ok;
        logic                    wr;
        logic [NUM_CHANNELS-1:0] active;
        logic [2:0]              acts;
        logic                    down;
        logic [COUNT_WIDTH-1:0]  step;
        logic [SLOT_W-1:0]       slot;
        logic [WORD_W-1:0]       tcr_v;

        flags_next = flags_reg;
        run_next   = run_reg;
        hold_next  = hold_reg;
        dir_next   = dir_reg;
        pl_next    = pl_reg;
        pc_next    = pc_reg;
        act_next   = act_reg;
        mat_next   = mat_reg;
        cnt_next   = cnt_reg;
        rdata_next = '0;

        alias_v  = addr_reg[ALIAS_W-1:0];
        sel      = addr_reg[ADDR_W-1:ALIAS_W];
        alias_ok = (alias_v == ALIAS_WR) || (alias_v == ALIAS_SET) || (alias_v == ALIAS_CLR);
        wr       = (func_reg == FUNC_WRITE);
        active   = run_reg & ~hold_reg;
        slot     = '0;
        tcr_v    = WORD_W'(run_reg) | (WORD_W'(hold_reg) << HOLD_LSB);
        acts     = '0;
        down     = 1'b0;
        step     = '0;

        case (func_reg)
            FUNC_TICK: begin
                for (int i = 0; i < NUM_CHANNELS; i++) begin
                    if (hold_reg[i]) begin
                        cnt_next[i] = '0;
                    end
                end
                if (active != '0) begin
                    if (pc_reg >= pl_reg) begin
                        pc_next = '0;
                        for (int i = 0; i < NUM_CHANNELS; i++) begin
                            if (active[i]) begin
                                acts = act_reg[3*i +: 3];
                                down = (dir_reg[4*i +: 2] == DIR_DOWN);
                                step = down ? cnt_reg[i] - COUNT_WIDTH'(1)
                                            : cnt_reg[i] + COUNT_WIDTH'(1);
                                if (cnt_reg[i] == mat_reg[i]) begin
                                    // match: flag, reset, stop
                                    if (acts[0]) flags_next[i] = 1'b1;
                                    if (acts[1]) begin
                                        cnt_next[i] = '0;
                                    end else if (!acts[2]) begin
                                        cnt_next[i] = step;
                                    end
                                    if (acts[2]) run_next[i] = 1'b0;
                                end else begin
                                    cnt_next[i] = step;
                                end
                            end
                        end
                    end else begin
                        pc_next = pc_reg + WORD_W'(1);
                    end
                end
            end
            FUNC_READ, FUNC_WRITE: begin
                if (alias_ok) begin
                    unique case (sel) inside
                        REG_IR: begin
                            if (wr) begin
                                // plain write clears the bits written as 1
                                flags_next = (alias_v == ALIAS_SET)
                                           ? flags_reg | wdata_reg[NUM_CHANNELS-1:0]
                                           : flags_reg & ~wdata_reg[NUM_CHANNELS-1:0];
                            end else begin
                                rdata_next = WORD_W'(flags_reg);
                            end
                        end
                        REG_TCR: begin
                            if (wr) begin
                                tcr_v     = merge(tcr_v, wdata_reg, alias_v);
                                run_next  = tcr_v[NUM_CHANNELS-1:0];
                                hold_next = tcr_v[HOLD_LSB +: NUM_CHANNELS];
                            end else begin
                                rdata_next = tcr_v;
                            end
                        end
                        REG_DIR: begin
                            if (wr) begin
                                dir_next = DIR_W'(merge(WORD_W'(dir_reg), wdata_reg, alias_v));
                            end else begin
                                rdata_next = WORD_W'(dir_reg);
                            end
                        end
                        [REG_CNT0:REG_CNT3]: begin
                            slot = SLOT_W'(sel - REG_CNT0);
                            if (!wr) begin
                                for (int i = 0; i < NUM_CHANNELS; i++) begin
                                    if (slot == SLOT_W'(i)) rdata_next = WORD_W'(cnt_reg[i]);
                                end
                            end
                        end
                        REG_PR: begin
                            if (wr) begin
                                pl_next = merge(pl_reg, wdata_reg, alias_v);
                            end else begin
                                rdata_next = pl_reg;
                            end
                        end
                        REG_PC: begin
                            if (!wr) rdata_next = pc_reg;
                        end
                        REG_MCR: begin
                            if (wr) begin
                                act_next = ACT_W'(merge(WORD_W'(act_reg), wdata_reg, alias_v));
                            end else begin
                                rdata_next = WORD_W'(act_reg);
                            end
                        end
                        [REG_MAT0:REG_MAT3]: begin
                            slot = SLOT_W'(sel - REG_MAT0);
                            for (int i = 0; i < NUM_CHANNELS; i++) begin
                                if (slot == SLOT_W'(i)) begin
                                    if (wr) begin
                                        mat_next[i] = COUNT_WIDTH'(merge(WORD_W'(mat_reg[i]),
                                                                         wdata_reg, alias_v));
                                    end else begin
                                        rdata_next = WORD_W'(mat_reg[i]);
                                    end
                                end
                            end
                        end
                        default: begin
                            // unmapped: read 0, write dropped
                        end
                    endcase
                end
            end
            default: begin
                // unused function code: no effect
            end
        endcase

        // reads never change state
        if (func_reg == FUNC_READ) begin
            flags_next = flags_reg;
        end

        irq_next = |flags_next;
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            func_reg  <= s_tuser;
            addr_reg  <= s_tdata[ADDR_W-1:0];
            wdata_reg <= s_tdata[ADDR_W +: WORD_W];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            rdata_reg <= rdata_next;
            irq_reg   <= irq_next;
        end
    end

    // timer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
            run_reg   <= '0;
            hold_reg  <= '0;
            dir_reg   <= '0;
            pl_reg    <= '0;
            pc_reg    <= '0;
            act_reg   <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                mat_reg[i] <= '0;
                cnt_reg[i] <= '0;
            end
        end else if (advance) begin
            flags_reg <= flags_next;
            run_reg   <= run_next;
            hold_reg  <= hold_next;
            dir_reg   <= dir_next;
            pl_reg    <= pl_next;
            pc_reg    <= pc_next;
            act_reg   <= act_next;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                mat_reg[i] <= mat_next[i];
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

endmodule

/* tb/timer_result_checker.sv */
// Checker for the match timer: predicts each result word from the input stream and compares.
module timer_result_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [fcmt_pkg::S_TDATA_W-1:0]  s_tdata,   // addr[8:0], wdata[40:9]
    input  logic [fcmt_pkg::FUNC_W-1:0]     s_tuser,   // func[1:0]
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [fcmt_pkg::M_TDATA_W-1:0]  m_tdata,   // rdata[31:0], irq[32]
    output int                              n_pending,
    output int                              n_errors
);
    import fcmt_pkg::*;

    localparam int COUNT_W_T = COUNT_WIDTH;

    typedef struct packed {
        logic [WORD_W-1:0] rdata;
        logic              irq;
    } timer_reply_t;

    timer_reply_t pending_replies[$];

    // mirror of the timer state
    logic [NUM_CHANNELS-1:0] flags;
    logic [NUM_CHANNELS-1:0] run_en;
    logic [NUM_CHANNELS-1:0] hold;
    logic [DIR_W-1:0]        dir_codes;
    logic [WORD_W-1:0]       pre_limit;
    logic [WORD_W-1:0]       pre_count;
    logic [ACT_W-1:0]        actions;
    logic [COUNT_W_T-1:0]    match_val [NUM_CHANNELS];
    logic [COUNT_W_T-1:0]    count_val [NUM_CHANNELS];

    function automatic logic [WORD_W-1:0] apply_alias(input logic [WORD_W-1:0] cur,
                                                      input logic [WORD_W-1:0] w,
                                                      input alias_t al);
        if (al == ALIAS_SET) return cur | w;
        if (al == ALIAS_CLR) return cur & ~w;
        return w;
    endfunction

    function automatic void clear_timer();
        flags     = '0;
        run_en    = '0;
        hold      = '0;
        dir_codes = '0;
        pre_limit = '0;
        pre_count = '0;
        actions   = '0;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            match_val[i] = '0;
            count_val[i] = '0;
        end
    endfunction

    function automatic void count_step(input int ch);
        logic [2:0]           act;
        logic                 down;
        logic [COUNT_W_T-1:0] nxt;
        act  = actions[3*ch +: 3];
        down = (dir_codes[4*ch +: 2] == DIR_DOWN);
        nxt  = down ? count_val[ch] - COUNT_W_T'(1) : count_val[ch] + COUNT_W_T'(1);
        if (count_val[ch] == match_val[ch]) begin
            if (act[0]) flags[ch] = 1'b1;
            if (act[1]) count_val[ch] = '0;
            else if (!act[2]) count_val[ch] = nxt;
            if (act[2]) run_en[ch] = 1'b0;
        end else begin
            count_val[ch] = nxt;
        end
    endfunction

    function automatic void timer_tick();
        logic [NUM_CHANNELS-1:0] active;
        active = run_en & ~hold;
        for (int i = 0; i < NUM_CHANNELS; i++)
            if (hold[i]) count_val[i] = '0;
        if (active != '0) begin
            if (pre_count >= pre_limit) begin
                pre_count = '0;
                for (int i = 0; i < NUM_CHANNELS; i++)
                    if (active[i]) count_step(i);
            end else begin
                pre_count = pre_count + WORD_W'(1);
            end
        end
    endfunction

    function automatic logic [WORD_W-1:0] reg_access(input bit wr,
                                                     input logic [ADDR_W-1:0] a,
                                                     input logic [WORD_W-1:0] w);
        alias_t            al;
        reg_sel_t          sel;
        int                ch;
        logic [WORD_W-1:0] v;
        logic [WORD_W-1:0] rd;
        al  = a[ALIAS_W-1:0];
        sel = a[ADDR_W-1:ALIAS_W];
        rd  = '0;
        if (al != ALIAS_WR && al != ALIAS_SET && al != ALIAS_CLR) return '0;
        if (sel == REG_IR) begin
            // plain write to IR clears the ones written
            if (!wr) rd = WORD_W'(flags);
            else if (al == ALIAS_WR) flags = flags & ~w[NUM_CHANNELS-1:0];
            else begin
                v = apply_alias(WORD_W'(flags), w, al);
                flags = v[NUM_CHANNELS-1:0];
            end
        end else if (sel == REG_TCR) begin
            v = WORD_W'(run_en) | (WORD_W'(hold) << HOLD_LSB);
            if (!wr) rd = v;
            else begin
                v      = apply_alias(v, w, al);
                run_en = v[NUM_CHANNELS-1:0];
                hold   = v[HOLD_LSB +: NUM_CHANNELS];
            end
        end else if (sel == REG_DIR) begin
            if (!wr) rd = WORD_W'(dir_codes);
            else begin
                v = apply_alias(WORD_W'(dir_codes), w, al);
                dir_codes = v[DIR_W-1:0];
            end
        end else if (sel >= REG_CNT0 && sel <= REG_CNT3) begin
            ch = int'(sel - REG_CNT0);
            if (!wr) rd = WORD_W'(count_val[ch]);
        end else if (sel == REG_PR) begin
            if (!wr) rd = pre_limit;
            else pre_limit = apply_alias(pre_limit, w, al);
        end else if (sel == REG_PC) begin
            if (!wr) rd = pre_count;
        end else if (sel == REG_MCR) begin
            if (!wr) rd = WORD_W'(actions);
            else begin
                v = apply_alias(WORD_W'(actions), w, al);
                actions = v[ACT_W-1:0];
            end
        end else if (sel >= REG_MAT0 && sel <= REG_MAT3) begin
            ch = int'(sel - REG_MAT0);
            if (!wr) rd = WORD_W'(match_val[ch]);
            else begin
                v = apply_alias(WORD_W'(match_val[ch]), w, al);
                match_val[ch] = v[COUNT_W_T-1:0];
            end
        end
        return rd;
    endfunction

    function automatic timer_reply_t advance_timer(input func_t f,
                                                   input logic [ADDR_W-1:0] a,
                                                   input logic [WORD_W-1:0] w);
        timer_reply_t r;
        r.rdata = '0;
        case (f)
            FUNC_TICK:  timer_tick();
            FUNC_READ:  r.rdata = reg_access(1'b0, a, w);
            FUNC_WRITE: void'(reg_access(1'b1, a, w));
            default:    ;
        endcase
        r.irq = |flags;
        return r;
    endfunction

    initial begin
        n_pending = 0;
        n_errors  = 0;
        clear_timer();
    end

    always @(posedge aclk) begin
        timer_reply_t want;
        if (!aresetn) begin
            clear_timer();
            pending_replies.delete();
        end else begin
            if (s_tvalid && s_tready)
                pending_replies.push_back(advance_timer(s_tuser, s_tdata[ADDR_W-1:0],
                                                        s_tdata[ADDR_W +: WORD_W]));
            if (m_tvalid && m_tready) begin
                if (pending_replies.size() == 0) begin
                    $error("unexpected result word: rdata %h irq %b",
                           m_tdata[WORD_W-1:0], m_tdata[WORD_W]);
                    n_errors++;
                end else begin
                    want = pending_replies.pop_front();
                    if (m_tdata[WORD_W-1:0] !== want.rdata) begin
                        $error("rdata: expected %h, actual %h", want.rdata, m_tdata[WORD_W-1:0]);
                        n_errors++;
                    end
                    if (m_tdata[WORD_W] !== want.irq) begin
                        $error("irq: expected %b, actual %b", want.irq, m_tdata[WORD_W]);
                        n_errors++;
                    end
                end
            end
        end
        n_pending = pending_replies.size();
    end

endmodule

/* tb/tb_four_channel_match_timer_unit.sv */
// Top of the match timer testbench: clock, reset, word stimulus, result sink and verdict.
module tb_four_channel_match_timer_unit;
    import fcmt_pkg::*;

    localparam int ITEM_GOAL    = 1375;     // directed words plus about 1350 random ones
    localparam int CYCLE_LIMIT  = 400000;   // far above the slowest legal run
    localparam int DRAIN_CYCLES = 8;        // result lags its word by the input and result registers

    // deliberately bad offsets and codes
    localparam func_t             FUNC_UNUSED  = 2'd3;
    localparam alias_t            ALIAS_ODD    = 4'h2;
    localparam alias_t            ALIAS_UNUSED = 4'hC;
    localparam reg_sel_t          REG_UNMAPPED = 5'h0E;
    localparam logic [ADDR_W-1:0] ADDR_MAX     = '1;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // addr[8:0], wdata[40:9]
    logic [FUNC_W-1:0]    s_tuser  = '0;   // func[1:0]
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // rdata[31:0], irq[32]

    int  n_pending;
    int  n_errors;
    int  words_sent = 0;
    int  n_ticks    = 0;
    int  n_reads    = 0;
    int  n_writes   = 0;
    int  n_bursts   = 0;
    int  cycles     = 0;
    bit  steady     = 1'b0;    // both sides run without gaps while set
    bit  sink_go    = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    four_channel_match_timer_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    timer_result_checker u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .n_pending (n_pending),
        .n_errors  (n_errors)
    );

    // Watchdog: also catches predictions that never get a result word.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("four_channel_match_timer_unit: mismatch");
            $finish;
        end
    end

    function automatic logic [ADDR_W-1:0] reg_addr(input reg_sel_t sel, input alias_t al);
        return {sel, al};
    endfunction

    // Offers one word. Entered right after a rising edge, leaves right after the
    // edge that took the word. Ready is looked at on the falling edge, where
    // nothing is changing, so the handshake check has no race.
    task automatic send_word(input func_t f, input logic [ADDR_W-1:0] a,
                             input logic [WORD_W-1:0] w);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {{(S_TDATA_W - ADDR_W - WORD_W){1'b0}}, w, a};
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        words_sent++;
        case (f)
            FUNC_TICK:  n_ticks++;
            FUNC_READ:  n_reads++;
            FUNC_WRITE: n_writes++;
            default:    ;
        endcase
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (n_pending != 0);
        @(posedge aclk);
    endtask

    // Any mapped register, any of the three aliases.
    task automatic read_any_reg();
        alias_t al;
        case ($urandom_range(0, 2))
            0:       al = ALIAS_WR;
            1:       al = ALIAS_SET;
            default: al = ALIAS_CLR;
        endcase
        send_word(FUNC_READ, reg_addr(reg_sel_t'($urandom_range(0, REG_MAT3)), al), $urandom);
    endtask

    // Well-formed timer run: prescaler, match setup, direction, enables,
    // then a burst of ticks mixed with reads and flag/enable pokes.
    // Small match values and prescale limits keep matches frequent.
    task automatic timer_run();
        int n;
        send_word(FUNC_WRITE, reg_addr(REG_PR, ALIAS_WR), $urandom_range(0, 3));
        send_word(FUNC_WRITE, reg_addr(REG_MCR, ALIAS_WR), $urandom);
        for (int ch = 0; ch < NUM_CHANNELS; ch++)
            send_word(FUNC_WRITE, reg_addr(reg_sel_t'(REG_MAT0 + ch), ALIAS_WR),
                      $urandom_range(0, 24));
        send_word(FUNC_WRITE, reg_addr(REG_DIR, ALIAS_WR), $urandom);
        if ($urandom_range(0, 1)) begin
            // hold pulse zeroes the counters left over from the last run
            send_word(FUNC_WRITE, reg_addr(REG_TCR, ALIAS_WR), 32'hF0);
            send_word(FUNC_TICK, '0, $urandom);
        end
        send_word(FUNC_WRITE, reg_addr(REG_TCR, ALIAS_WR),
                  WORD_W'({$urandom_range(0, 3) == 0 ? 4'($urandom) : 4'h0, 4'($urandom)}));
        n = $urandom_range(10, 40);
        repeat (n) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: send_word(FUNC_TICK, ADDR_W'($urandom), $urandom);
                6, 7:             read_any_reg();
                8: send_word(FUNC_WRITE, reg_addr(REG_IR,
                                 $urandom_range(0, 1) ? ALIAS_WR : ALIAS_CLR), $urandom);
                default: send_word(FUNC_WRITE, reg_addr(REG_TCR,
                                 $urandom_range(0, 1) ? ALIAS_SET : ALIAS_CLR),
                                 $urandom_range(0, 255));
            endcase
        end
    endtask

    // Sink: draws a stall before each result word, none while steady.
    initial begin
        int stall;
        wait (sink_go);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(negedge aclk); while (!m_tvalid);
            @(posedge aclk);
        end
    end

    initial begin
        bit drained_once;
        drained_once = 1'b0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        sink_go = 1'b1;

        // --- directed words ---
        send_word(FUNC_READ, reg_addr(REG_IR, ALIAS_WR), '0);             // reset value
        send_word(FUNC_WRITE, reg_addr(REG_TCR, ALIAS_SET), '1);          // run and hold all
        send_word(FUNC_TICK, '0, '0);                                     // held: no count
        send_word(FUNC_WRITE, reg_addr(REG_TCR, ALIAS_CLR), 32'hF0);      // release holds
        send_word(FUNC_WRITE, reg_addr(REG_DIR, ALIAS_WR), 32'hFFFF_3211); // 0,1 down; 10, 11 up
        send_word(FUNC_TICK, '0, '1);                                     // down wraps below 0
        send_word(FUNC_READ, reg_addr(REG_CNT0, ALIAS_WR), '0);
        send_word(FUNC_WRITE, reg_addr(REG_DIR, ALIAS_CLR), '1);          // all up again
        send_word(FUNC_TICK, '0, '0);                                     // up wraps to 0
        send_word(FUNC_READ, reg_addr(reg_sel_t'(REG_CNT0 + 1), ALIAS_SET), '0);
        send_word(FUNC_WRITE, reg_addr(reg_sel_t'(REG_MAT0 + 2), ALIAS_WR), 32'd2);
        send_word(FUNC_WRITE, reg_addr(REG_MCR, ALIAS_SET), '1);          // irq+reset+stop
        send_word(FUNC_TICK, '0, '0);                                     // matches fire
        send_word(FUNC_READ, reg_addr(REG_IR, ALIAS_CLR), '0);
        send_word(FUNC_WRITE, reg_addr(REG_IR, ALIAS_WR), 32'h1);         // write-one-to-clear
        send_word(FUNC_WRITE, reg_addr(REG_IR, ALIAS_SET), '1);
        send_word(FUNC_WRITE, reg_addr(REG_PR, ALIAS_WR), '1);
        send_word(FUNC_WRITE, reg_addr(REG_PC, ALIAS_WR), 32'd5);         // read-only
        send_word(FUNC_WRITE, reg_addr(REG_CNT3, ALIAS_WR), 32'd5);       // read-only
        send_word(FUNC_READ, reg_addr(REG_PC, ALIAS_WR), '0);
        send_word(FUNC_UNUSED, reg_addr(REG_TCR, ALIAS_WR), '1);          // no effect
        send_word(FUNC_READ, reg_addr(REG_IR, ALIAS_ODD), '0);            // unaligned
        send_word(FUNC_WRITE, reg_addr(REG_PR, ALIAS_UNUSED), '0);        // alias 0xc
        send_word(FUNC_READ, reg_addr(REG_UNMAPPED, ALIAS_WR), '0);
        send_word(FUNC_WRITE, ADDR_MAX, '1);                              // top of the space

        // --- random part ---
        while (words_sent < ITEM_GOAL) begin
            steady = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 9))
                0, 1: begin
                    // noise: any code, any offset, any data
                    repeat ($urandom_range(5, 20))
                        send_word(func_t'($urandom_range(0, 3)), ADDR_W'($urandom), $urandom);
                end
                2: begin
                    repeat ($urandom_range(3, 10)) read_any_reg();
                end
                default: begin
                    timer_run();
                    n_bursts++;
                end
            endcase
            // once, mid run: hold off until every result is back
            if (!drained_once && words_sent > ITEM_GOAL / 2) begin
                wait_drained();
                drained_once = 1'b1;
            end
        end

        steady = 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);

        $display("Covered %0d words: %0d ticks, %0d reads, %0d writes, %0d timer runs.",
                 words_sent, n_ticks, n_reads, n_writes, n_bursts);
        $display("Both sides idled at random, with gap-free stretches and one full drain.");
        if (n_errors == 0)
            $display("four_channel_match_timer_unit: match");
        else
            $display("four_channel_match_timer_unit: mismatch");
        $finish;
    end

endmodule
